FILE: sv/tsp_pkg.sv
// Shared types and codes for the timer slot pool.
package tsp_pkg;

  localparam int CMD_W    = 2;
  localparam int SLOT_W   = 3;
  localparam int COUNT_W  = 32;
  localparam int TAG_W    = 16;
  localparam int STATUS_W = 3;

  localparam logic [CMD_W-1:0] CMD_START = 2'd0;
  localparam logic [CMD_W-1:0] CMD_TICK  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_REARM = 2'd2;

  localparam logic [STATUS_W-1:0] ST_STARTED = 3'd0;
  localparam logic [STATUS_W-1:0] ST_REFUSED = 3'd1;
  localparam logic [STATUS_W-1:0] ST_EXPIRED = 3'd2;
  localparam logic [STATUS_W-1:0] ST_COUNTED = 3'd3;
  localparam logic [STATUS_W-1:0] ST_IGNORED = 3'd4;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_DONE
  } ctrl_state_t;

  typedef struct packed {
    logic load;
    logic exec;
  } dp_cmd_t;

endpackage

FILE: sv/tsp_ctrl.sv
// Controller state machine: sequences transfer capture, execution and result strobe.
module tsp_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  output logic             out_valid,
  output tsp_pkg::dp_cmd_t dp_cmd
);

  tsp_pkg::ctrl_state_t state_r;
  tsp_pkg::ctrl_state_t state_nxt;
  logic                 accept;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tsp_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    busy        = 1'b0;
    out_valid   = 1'b0;
    dp_cmd.exec = 1'b0;
    state_nxt   = state_r;
    case (state_r)
      tsp_pkg::S_IDLE: begin
        if (start) begin
          state_nxt = tsp_pkg::S_EXEC;
        end
      end
      tsp_pkg::S_EXEC: begin
        busy        = 1'b1;
        dp_cmd.exec = 1'b1;
        state_nxt   = tsp_pkg::S_DONE;
      end
      tsp_pkg::S_DONE: begin
        out_valid = 1'b1;
        state_nxt = start ? tsp_pkg::S_EXEC : tsp_pkg::S_IDLE;
      end
      default: begin
        state_nxt = tsp_pkg::S_IDLE;
      end
    endcase
    accept      = start && !busy;
    dp_cmd.load = accept;
  end

  a_exec_then_result: assert property (@(posedge clk) disable iff (!rst_n)
    dp_cmd.exec |=> out_valid)
    else $error("execution not followed by result strobe");

  a_accept_then_exec: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> dp_cmd.exec)
    else $error("accepted transfer not executed");

  a_result_needs_exec: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(dp_cmd.exec))
    else $error("result strobe without execution");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !busy && !out_valid)
    else $error("activity right after reset");

endmodule

FILE: sv/tsp_datapath.sv
// Datapath: slot state, free-slot search, countdown and result registers.
module tsp_datapath #(
  parameter int NUM_SLOTS = 5
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  tsp_pkg::dp_cmd_t                 dp_cmd,
  input  logic [tsp_pkg::CMD_W-1:0]        in_cmd,
  input  logic [tsp_pkg::SLOT_W-1:0]       in_slot,
  input  logic [tsp_pkg::COUNT_W-1:0]      in_count,
  input  logic [tsp_pkg::TAG_W-1:0]        in_tag,
  output logic [tsp_pkg::STATUS_W-1:0]     out_status,
  output logic [tsp_pkg::SLOT_W-1:0]       out_slot_out,
  output logic [tsp_pkg::TAG_W-1:0]        out_tag_out
);

  localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int WIDE_W = IDX_W + tsp_pkg::SLOT_W;

  logic [tsp_pkg::CMD_W-1:0]    cmd_r;
  logic [tsp_pkg::SLOT_W-1:0]   slot_r;
  logic [tsp_pkg::COUNT_W-1:0]  count_r;
  logic [tsp_pkg::TAG_W-1:0]    tag_r;

  logic                         busy_r    [NUM_SLOTS];
  logic                         waiting_r [NUM_SLOTS];
  logic [tsp_pkg::COUNT_W-1:0]  cnt_r     [NUM_SLOTS];
  logic [tsp_pkg::TAG_W-1:0]    stag_r    [NUM_SLOTS];

  logic [tsp_pkg::STATUS_W-1:0] status_r, status_nxt;
  logic [tsp_pkg::SLOT_W-1:0]   slot_out_r, slot_out_nxt;
  logic [tsp_pkg::TAG_W-1:0]    tag_out_r, tag_out_nxt;

  logic [WIDE_W-1:0]            slot_wide;
  logic                         in_range;
  logic [IDX_W-1:0]             idx;
  logic                         found;
  logic [IDX_W-1:0]             free_idx;
  logic [tsp_pkg::COUNT_W-1:0]  cnt_dec;
  logic                         do_start, do_tick, do_rearm;

  always_ff @(posedge clk) begin
    if (dp_cmd.load) begin
      cmd_r   <= in_cmd;
      slot_r  <= in_slot;
      count_r <= in_count;
      tag_r   <= in_tag;
    end
  end

  always_comb begin
    slot_wide = WIDE_W'(slot_r);
    in_range  = slot_wide < WIDE_W'(NUM_SLOTS);
    idx       = slot_wide[IDX_W-1:0];
    found     = 1'b0;
    free_idx  = '0;
    for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
      if (!busy_r[i]) begin
        found    = 1'b1;
        free_idx = IDX_W'(i);
      end
    end
    cnt_dec      = in_range ? cnt_r[idx] - 1'b1 : '0;
    do_start     = 1'b0;
    do_tick      = 1'b0;
    do_rearm     = 1'b0;
    status_nxt   = tsp_pkg::ST_IGNORED;
    slot_out_nxt = slot_r;
    tag_out_nxt  = '0;
    case (cmd_r)
      tsp_pkg::CMD_START: begin
        slot_out_nxt = '0;
        if (count_r != '0 && found) begin
          do_start     = 1'b1;
          status_nxt   = tsp_pkg::ST_STARTED;
          slot_out_nxt = tsp_pkg::SLOT_W'(free_idx);
        end else begin
          status_nxt = tsp_pkg::ST_REFUSED;
        end
      end
      tsp_pkg::CMD_TICK: begin
        if (in_range && busy_r[idx] && !waiting_r[idx]) begin
          do_tick = 1'b1;
          if (cnt_dec == '0) begin
            status_nxt  = tsp_pkg::ST_EXPIRED;
            tag_out_nxt = stag_r[idx];
          end else begin
            status_nxt = tsp_pkg::ST_COUNTED;
          end
        end
      end
      tsp_pkg::CMD_REARM: begin
        if (in_range && busy_r[idx] && waiting_r[idx]) begin
          do_rearm   = 1'b1;
          status_nxt = tsp_pkg::ST_COUNTED;
        end
      end
      default: begin
        status_nxt = tsp_pkg::ST_IGNORED;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
        busy_r[i]    <= 1'b0;
        waiting_r[i] <= 1'b0;
      end
    end else if (dp_cmd.exec) begin
      if (do_start) begin
        busy_r[free_idx]    <= 1'b1;
        waiting_r[free_idx] <= 1'b0;
      end
      if (do_tick && cnt_dec == '0) begin
        waiting_r[idx] <= 1'b1;
      end
      if (do_rearm) begin
        waiting_r[idx] <= 1'b0;
        if (count_r == '0) begin
          busy_r[idx] <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (dp_cmd.exec) begin
      if (do_start) begin
        cnt_r[free_idx]  <= count_r;
        stag_r[free_idx] <= tag_r;
      end
      if (do_tick) begin
        cnt_r[idx] <= cnt_dec;
      end
      if (do_rearm && count_r != '0) begin
        cnt_r[idx] <= count_r;
      end
      status_r   <= status_nxt;
      slot_out_r <= slot_out_nxt;
      tag_out_r  <= tag_out_nxt;
    end
  end

  assign out_status   = status_r;
  assign out_slot_out = slot_out_r;
  assign out_tag_out  = tag_out_r;

endmodule

FILE: sv/timer_slot_pool_top.sv
// Top level of the timer slot pool: controller and datapath.
//
// Usage: drive in_cmd, in_slot, in_count and in_tag with start high; the
// transfer is taken at a rising edge where start is high and busy is low.
// Commands: start takes the lowest free slot, tick counts one slot down,
// rearm reloads an expired slot or frees it with a zero count.
// Exactly one result follows every transfer: out_valid is high for one
// cycle with out_status, out_slot_out and out_tag_out.
// The accepting edge moves the controller to EXEC, where the datapath
// evaluates the item; the result strobe is shown in the DONE state that follows EXEC.
// busy is high only in the cycle the datapath evaluates the item, and a new
// item may be taken in the cycle its predecessor's result is shown.
// Reset (rst_n low, synchronous) frees every slot; counts and tags are
// loaded on start and need no clearing.
// The receiver cannot stall: a result is taken in the cycle it is shown.
module timer_slot_pool_top #(
  parameter int NUM_SLOTS = 5
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [tsp_pkg::CMD_W-1:0]     in_cmd,
  input  logic [tsp_pkg::SLOT_W-1:0]    in_slot,
  input  logic [tsp_pkg::COUNT_W-1:0]   in_count,
  input  logic [tsp_pkg::TAG_W-1:0]     in_tag,
  output logic                          out_valid,
  output logic [tsp_pkg::STATUS_W-1:0]  out_status,
  output logic [tsp_pkg::SLOT_W-1:0]    out_slot_out,
  output logic [tsp_pkg::TAG_W-1:0]     out_tag_out
);

  tsp_pkg::dp_cmd_t dp_cmd;

  tsp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .out_valid (out_valid),
    .dp_cmd    (dp_cmd)
  );

  tsp_datapath #(
    .NUM_SLOTS (NUM_SLOTS)
  ) u_datapath (
    .clk          (clk),
    .rst_n        (rst_n),
    .dp_cmd       (dp_cmd),
    .in_cmd       (in_cmd),
    .in_slot      (in_slot),
    .in_count     (in_count),
    .in_tag       (in_tag),
    .out_status   (out_status),
    .out_slot_out (out_slot_out),
    .out_tag_out  (out_tag_out)
  );

endmodule
